>>> rtl/lsps_pkg.sv
// Shared types and constants for the line sensor PID steering block.
package lsps_pkg;

    // Sensor array and fixed point format.
    localparam int SENSOR_COUNT = 8;
    localparam int FRAC_BITS    = 8;
    localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
    localparam int SUM_W        = $clog2(SENSOR_COUNT * (SENSOR_COUNT - 1) / 2 + 1);
    localparam int NUM_W        = SUM_W + FRAC_BITS;
    localparam int STEP_W       = $clog2(NUM_W);

    // Field widths.
    localparam int SENS_W = 8;
    localparam int POS_W  = 11;
    localparam int GAIN_W = 16;
    localparam int DUTY_W = 10;
    localparam int CORR_W = 11;
    localparam int ERR_W  = 12;
    localparam int DIFF_W = ERR_W + 1;
    localparam int PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int INT_W  = 40;
    localparam int TOT_W  = INT_W + 2;
    localparam int SHF_W  = TOT_W - FRAC_BITS;
    localparam int SUMD_W = DUTY_W + 2;

    localparam logic signed [SUMD_W-1:0] PWM_TOP = SUMD_W'(1000);

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_SET_POINT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_SPEED = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_CORR_LIMIT = 3'd5;

    // Register reset values.
    localparam logic [POS_W-1:0]  RST_SET_POINT  = 11'd896;
    localparam logic [GAIN_W-1:0] RST_GAIN_P     = 16'd150;
    localparam logic [GAIN_W-1:0] RST_GAIN_I     = 16'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_D     = 16'd0;
    localparam logic [DUTY_W-1:0] RST_BASE_SPEED = 10'd500;
    localparam logic [DUTY_W-1:0] RST_CORR_LIMIT = 10'd500;

    // Controller settings handed from the register bank to the PID core.
    typedef struct packed {
        logic [POS_W-1:0]  set_point;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [DUTY_W-1:0] base_speed;
        logic [DUTY_W-1:0] corr_limit;
    } t_pid_cfg;

endpackage

>>> rtl/lsps_centroid.sv
// Line position finder: set bit count and index sum, then a bit-serial divide.
module lsps_centroid (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [lsps_pkg::SENS_W-1:0]     i_bits,
    output logic                            o_done,
    output logic [lsps_pkg::POS_W-1:0]      o_position,
    output logic                            o_lost
);

    logic [lsps_pkg::CNT_W-1:0]  w_cnt;
    logic [lsps_pkg::SUM_W-1:0]  w_sum;
    logic [lsps_pkg::CNT_W:0]    w_trial;
    logic                        w_qbit;

    logic                        r_run;
    logic                        r_done;
    logic                        r_lost;
    logic [lsps_pkg::STEP_W-1:0] r_step;
    logic [lsps_pkg::CNT_W-1:0]  r_div;
    logic [lsps_pkg::CNT_W-1:0]  r_rem;
    logic [lsps_pkg::NUM_W-1:0]  r_nq;

    // Count the set sensors and add up their indices.
    always_comb begin
        w_cnt = '0;
        w_sum = '0;
        for (int i = 0; i < lsps_pkg::SENSOR_COUNT; i++) begin
            if (i_bits[i]) begin
                w_cnt = w_cnt + lsps_pkg::CNT_W'(1);
                w_sum = w_sum + lsps_pkg::SUM_W'(i);
            end
        end
    end

    // One restoring divide step: shift in the next numerator bit and try to subtract.
    assign w_trial = {r_rem, r_nq[lsps_pkg::NUM_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_div});

    // Control of the divide sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= '0;
                if (w_cnt == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                r_step <= r_step + lsps_pkg::STEP_W'(1);
                if (r_step == lsps_pkg::STEP_W'(lsps_pkg::NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Numerator and quotient share one shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq   <= {w_sum, {lsps_pkg::FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_div  <= w_cnt;
            r_lost <= (w_cnt == '0);
        end else if (r_run) begin
            r_nq  <= {r_nq[lsps_pkg::NUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? lsps_pkg::CNT_W'(w_trial - {1'b0, r_div})
                            : lsps_pkg::CNT_W'(w_trial);
        end
    end

    // With no set bit the shift register was loaded with zero, so the position reads zero.
    assign o_done     = r_done;
    assign o_lost     = r_lost;
    assign o_position = r_nq[lsps_pkg::POS_W-1:0];

endmodule

>>> rtl/lsps_pid_core.sv
// PID sequencer around one shared multiplier, with integral, clamping and duty logic.
module lsps_pid_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lsps_pkg::POS_W-1:0]          i_position,
    input  lsps_pkg::t_pid_cfg                  i_cfg,
    input  logic                                i_out_free,
    output logic                                o_done,
    output logic [lsps_pkg::DUTY_W-1:0]         o_left_duty,
    output logic [lsps_pkg::DUTY_W-1:0]         o_right_duty,
    output logic signed [lsps_pkg::CORR_W-1:0]  o_correction
);

    localparam logic [3:0] P_IDLE = 4'd0;
    localparam logic [3:0] P_ERR  = 4'd1;
    localparam logic [3:0] P_MI   = 4'd2;
    localparam logic [3:0] P_INT  = 4'd3;
    localparam logic [3:0] P_PRO  = 4'd4;
    localparam logic [3:0] P_DER  = 4'd5;
    localparam logic [3:0] P_SHF  = 4'd6;
    localparam logic [3:0] P_CLP  = 4'd7;
    localparam logic [3:0] P_OUT  = 4'd8;

    localparam int TW = lsps_pkg::TOT_W;
    localparam int SW = lsps_pkg::SHF_W;
    localparam int DW = lsps_pkg::SUMD_W;

    logic [3:0] r_state;
    logic [3:0] n_state;

    logic [lsps_pkg::POS_W-1:0]         r_pos;
    logic signed [lsps_pkg::ERR_W-1:0]  r_err;
    logic signed [lsps_pkg::ERR_W-1:0]  r_last_err;
    logic signed [lsps_pkg::DIFF_W-1:0] r_diff;
    logic signed [lsps_pkg::PROD_W-1:0] r_prod;
    logic signed [lsps_pkg::INT_W-1:0]  r_integral;
    logic signed [TW-1:0]               r_total;
    logic signed [SW-1:0]               r_shift;
    logic signed [lsps_pkg::CORR_W-1:0] r_corr;

    logic signed [lsps_pkg::GAIN_W:0]   w_mul_a;
    logic signed [lsps_pkg::DIFF_W-1:0] w_mul_b;
    logic signed [lsps_pkg::INT_W:0]    w_int_sum;
    logic signed [TW-1:0]               w_prod_ext;
    logic signed [TW-1:0]               w_tot_adj;
    logic signed [SW-1:0]               w_lim;
    logic signed [SW-1:0]               w_nlim;
    logic signed [DW-1:0]               w_left;
    logic signed [DW-1:0]               w_right;

    function automatic logic signed [lsps_pkg::DIFF_W-1:0] DIFF_SIGN_EXT(
        input logic signed [lsps_pkg::ERR_W-1:0] v
    );
        return {v[lsps_pkg::ERR_W-1], v};
    endfunction

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            P_IDLE:  if (i_start) n_state = P_ERR;
            P_ERR:   n_state = P_MI;
            P_MI:    n_state = P_INT;
            P_INT:   n_state = P_PRO;
            P_PRO:   n_state = P_DER;
            P_DER:   n_state = P_SHF;
            P_SHF:   n_state = P_CLP;
            P_CLP:   n_state = P_OUT;
            P_OUT:   if (i_out_free) n_state = P_IDLE;
            default: n_state = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand select for the shared multiplier: integral, proportional, derivative.
    always_comb begin
        case (r_state)
            P_MI: begin
                w_mul_a = $signed({1'b0, i_cfg.gain_i});
                w_mul_b = DIFF_SIGN_EXT(r_err);
            end
            P_INT: begin
                w_mul_a = $signed({1'b0, i_cfg.gain_p});
                w_mul_b = DIFF_SIGN_EXT(r_err);
            end
            default: begin
                w_mul_a = $signed({1'b0, i_cfg.gain_d});
                w_mul_b = r_diff;
            end
        endcase
    end

    // Integral add with saturation to the 40-bit signed range.
    assign w_int_sum = {r_integral[lsps_pkg::INT_W-1], r_integral}
                     + (lsps_pkg::INT_W + 1)'(r_prod);
    assign w_prod_ext = TW'(r_prod);

    // Truncation toward zero: bias negative values before the arithmetic shift.
    assign w_tot_adj = r_total + (r_total[TW-1] ? TW'((1 << lsps_pkg::FRAC_BITS) - 1) : '0);

    assign w_lim  = $signed({{(SW - lsps_pkg::DUTY_W){1'b0}}, i_cfg.corr_limit});
    assign w_nlim = -w_lim;

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last_err <= '0;
        end else begin
            if (r_state == P_INT) begin
                if (w_int_sum[lsps_pkg::INT_W] != w_int_sum[lsps_pkg::INT_W-1]) begin
                    r_integral <= w_int_sum[lsps_pkg::INT_W] ?
                                  {1'b1, {(lsps_pkg::INT_W-1){1'b0}}} :
                                  {1'b0, {(lsps_pkg::INT_W-1){1'b1}}};
                end else begin
                    r_integral <= w_int_sum[lsps_pkg::INT_W-1:0];
                end
            end
            if (r_state == P_DER) begin
                r_last_err <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        case (r_state)
            P_IDLE: begin
                if (i_start) r_pos <= i_position;
            end
            P_ERR: begin
                r_err <= $signed({1'b0, i_cfg.set_point}) - $signed({1'b0, r_pos});
            end
            P_MI: begin
                r_diff <= DIFF_SIGN_EXT(r_err) - DIFF_SIGN_EXT(r_last_err);
            end
            P_PRO: begin
                r_total <= TW'(r_integral) + w_prod_ext;
            end
            P_DER: begin
                r_total <= r_total + w_prod_ext;
            end
            P_SHF: begin
                r_shift <= w_tot_adj[TW-1:lsps_pkg::FRAC_BITS];
            end
            P_CLP: begin
                if (r_shift > w_lim) begin
                    r_corr <= lsps_pkg::CORR_W'(w_lim);
                end else if (r_shift < w_nlim) begin
                    r_corr <= lsps_pkg::CORR_W'(w_nlim);
                end else begin
                    r_corr <= r_shift[lsps_pkg::CORR_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Motor duties from the saturated correction.
    assign w_left  = $signed({2'b00, i_cfg.base_speed}) - DW'(r_corr);
    assign w_right = $signed({2'b00, i_cfg.base_speed}) + DW'(r_corr);

    always_comb begin
        if (w_left < 0) begin
            o_left_duty = '0;
        end else if (w_left > lsps_pkg::PWM_TOP) begin
            o_left_duty = lsps_pkg::PWM_TOP[lsps_pkg::DUTY_W-1:0];
        end else begin
            o_left_duty = w_left[lsps_pkg::DUTY_W-1:0];
        end
        if (w_right < 0) begin
            o_right_duty = '0;
        end else if (w_right > lsps_pkg::PWM_TOP) begin
            o_right_duty = lsps_pkg::PWM_TOP[lsps_pkg::DUTY_W-1:0];
        end else begin
            o_right_duty = w_right[lsps_pkg::DUTY_W-1:0];
        end
    end

    assign o_correction = r_corr;
    assign o_done       = (r_state == P_OUT) && i_out_free;

endmodule

>>> rtl/line_sensor_pid_steering.sv
// One word is in work at a time: the next word is accepted once the PID result of the last
// is handed to the output register. The 13-step centroid divide (skipped when no sensor bit
// is set) and the eight-step PID sequence around one shared multiplier set the pace.
// A finished result waits in the output register while the next word is accepted.
// Reset (synchronous, active low) restores the register defaults, clears the integral and
// the previous error, and empties the output register.
module line_sensor_pid_steering (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [lsps_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [lsps_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Sensor word stream.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] sensor_bits
    // Steering result stream.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [31:0]                         o_m_axis_tdata,  // [9:0] left_duty,
                                                                 // [19:10] right_duty,
                                                                 // [30:20] correction
    output logic                                o_m_axis_tuser   // [0] line_lost
);

    lsps_pkg::t_pid_cfg r_cfg;

    logic                               r_busy;
    logic                               r_lost;
    logic                               r_out_valid;
    logic [lsps_pkg::DUTY_W-1:0]        r_out_left;
    logic [lsps_pkg::DUTY_W-1:0]        r_out_right;
    logic [lsps_pkg::CORR_W-1:0]        r_out_corr;
    logic                               r_out_lost;

    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_cen_done;
    logic                               w_cen_lost;
    logic [lsps_pkg::POS_W-1:0]         w_position;
    logic                               w_pid_done;
    logic [lsps_pkg::DUTY_W-1:0]        w_left;
    logic [lsps_pkg::DUTY_W-1:0]        w_right;
    logic signed [lsps_pkg::CORR_W-1:0] w_corr;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // Register bank; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_point  <= lsps_pkg::RST_SET_POINT;
            r_cfg.gain_p     <= lsps_pkg::RST_GAIN_P;
            r_cfg.gain_i     <= lsps_pkg::RST_GAIN_I;
            r_cfg.gain_d     <= lsps_pkg::RST_GAIN_D;
            r_cfg.base_speed <= lsps_pkg::RST_BASE_SPEED;
            r_cfg.corr_limit <= lsps_pkg::RST_CORR_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lsps_pkg::CFG_SET_POINT:
                    r_cfg.set_point <= i_cfg_wdata[lsps_pkg::POS_W-1:0];
                lsps_pkg::CFG_GAIN_P:
                    r_cfg.gain_p <= i_cfg_wdata[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::CFG_GAIN_I:
                    r_cfg.gain_i <= i_cfg_wdata[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::CFG_GAIN_D:
                    r_cfg.gain_d <= i_cfg_wdata[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::CFG_BASE_SPEED:
                    r_cfg.base_speed <= i_cfg_wdata[lsps_pkg::DUTY_W-1:0];
                lsps_pkg::CFG_CORR_LIMIT:
                    r_cfg.corr_limit <= i_cfg_wdata[lsps_pkg::DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lsps_centroid u_centroid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_bits     (i_s_axis_tdata[lsps_pkg::SENS_W-1:0]),
        .o_done     (w_cen_done),
        .o_position (w_position),
        .o_lost     (w_cen_lost)
    );

    lsps_pid_core u_pid_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_cen_done),
        .i_position   (w_position),
        .i_cfg        (r_cfg),
        .i_out_free   (w_out_free),
        .o_done       (w_pid_done),
        .o_left_duty  (w_left),
        .o_right_duty (w_right),
        .o_correction (w_corr)
    );

    // One word in flight at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_pid_done) begin
            r_busy <= 1'b0;
        end
    end

    // Keep the line-lost flag until the PID result is ready.
    always_ff @(posedge i_clk) begin
        if (w_cen_done) begin
            r_lost <= w_cen_lost;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pid_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pid_done) begin
            r_out_left  <= w_left;
            r_out_right <= w_right;
            r_out_corr  <= w_corr;
            r_out_lost  <= r_lost;
        end
    end

    assign o_s_axis_tready = !r_busy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_corr, r_out_right, r_out_left};
    assign o_m_axis_tuser  = r_out_lost;

    // The block takes no second word while one is in work.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("sensor word accepted while another is in work");

    // Delivered duties never exceed the PWM top.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out_left <= 10'd1000) && (r_out_right <= 10'd1000))
        else $error("motor duty above PWM top");

    // The delivered correction stays inside the configured bound.
    a_corr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(r_out_corr) <= $signed({1'b0, r_cfg.corr_limit})) &&
            ($signed(r_out_corr) >= -$signed({1'b0, r_cfg.corr_limit})))
        else $error("correction outside configured limit");

endmodule
